// ===== hdl/circumcircle_incircle_test_top_assert.svh =====
// Assertion macros for the circumcircle and incircle test block.
// Used by the port checker; expects clk and rst in the scope of each use.
`ifndef CIRCUMCIRCLE_INCIRCLE_TEST_TOP_ASSERT_SVH
`define CIRCUMCIRCLE_INCIRCLE_TEST_TOP_ASSERT_SVH

// Checked on every clock edge, silenced while reset is high.
`define CCI_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CCI_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cci_pkg.sv =====
// Shared types and constants for the circumcircle and incircle test block.
// No dependencies.
package cci_pkg;

  // Depth of the queue between front and back, as a power of two.
  localparam int QDEPTH_LOG2 = 2;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hdl/cci_fifo.sv =====
// Short queue that decouples the front end from the arithmetic back end.
// Depends on cci_pkg.
module cci_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output cci_pkg::qstat_t  stat
);
  import cci_pkg::*;

  localparam int DEPTH = 2 ** QDEPTH_LOG2;

  logic [WIDTH-1:0]     mem [DEPTH];
  logic [QDEPTH_LOG2:0] wr_ptr;
  logic [QDEPTH_LOG2:0] rd_ptr;

  assign stat.full  = (wr_ptr - rd_ptr) == (QDEPTH_LOG2 + 1)'(DEPTH);
  assign stat.empty = wr_ptr == rd_ptr;
  assign rdata      = mem[rd_ptr[QDEPTH_LOG2-1:0]];

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      mem[wr_ptr[QDEPTH_LOG2-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !stat.full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !stat.empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cci_front.sv =====
// Front end: takes input requests and reduces them to offsets from vertex a.
// Depends on cci_pkg; feeds cci_fifo.
module cci_front #(
  parameter int COORD_WIDTH = 32,
  localparam int D  = COORD_WIDTH + 1,
  localparam int FW = 2 * COORD_WIDTH + 6 * D
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [8*COORD_WIDTH-1:0] s_tdata,
  input  cci_pkg::qstat_t          qstat,
  output logic                     push,
  output logic [FW-1:0]            pdata
);
  import cci_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                valid;
  logic [FW-1:0]       data;
  logic signed [W-1:0] ax, ay, bx, by_coord, cx, cy, dx, dy;
  logic signed [D-1:0] ba0, ba1, ca0, ca1, e0, e1;

  assign ax       = $signed(s_tdata[0*W +: W]);
  assign ay       = $signed(s_tdata[1*W +: W]);
  assign bx       = $signed(s_tdata[2*W +: W]);
  assign by_coord = $signed(s_tdata[3*W +: W]);
  assign cx       = $signed(s_tdata[4*W +: W]);
  assign cy       = $signed(s_tdata[5*W +: W]);
  assign dx       = $signed(s_tdata[6*W +: W]);
  assign dy       = $signed(s_tdata[7*W +: W]);

  // All later work is done relative to vertex a.
  assign ba0 = D'(bx) - D'(ax);
  assign ba1 = D'(by_coord) - D'(ay);
  assign ca0 = D'(cx) - D'(ax);
  assign ca1 = D'(cy) - D'(ay);
  assign e0  = D'(dx) - D'(ax);
  assign e1  = D'(dy) - D'(ay);

  assign s_tready = !valid || !qstat.full;
  assign push     = valid && !qstat.full;
  assign pdata    = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= {e1, e0, ca1, ca0, ba1, ba0, ay, ax};
    end
  end

endmodule

// ===== hdl/cci_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a payload
// carried alongside. Also reports whether the quotient rounds up. No dependencies.
module cci_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic          round_up,
  output logic [PW-1:0] pay_out
);

  logic          vld [NW];
  logic [DW-1:0] rem [NW];
  logic [NW-1:0] nq  [NW];
  logic [DW-1:0] dv  [NW];
  logic [PW-1:0] pay [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          pv;
    logic [DW-1:0] prem;
    logic [NW-1:0] pn;
    logic [DW-1:0] pd;
    logic [PW-1:0] pp;
    logic [DW:0]   tr;
    logic          ge;
    logic [DW:0]   nr;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = '0;
      assign pn   = num;
      assign pd   = den;
      assign pp   = pay_in;
    end else begin : g_next
      assign pv   = vld[k-1];
      assign prem = rem[k-1];
      assign pn   = nq[k-1];
      assign pd   = dv[k-1];
      assign pp   = pay[k-1];
    end

    // The numerator shifts out at the top while quotient bits enter below.
    assign tr = {prem, pn[NW-1]};
    assign ge = tr >= {1'b0, pd};
    assign nr = ge ? tr - {1'b0, pd} : tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= nr[DW-1:0];
        nq[k]  <= {pn[NW-2:0], ge};
        dv[k]  <= pd;
        pay[k] <= pp;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = nq[NW-1];
  assign round_up  = {rem[NW-1], 1'b0} >= {1'b0, dv[NW-1]};
  assign pay_out   = pay[NW-1];

endmodule

// ===== hdl/cci_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a payload
// carried alongside. No dependencies.
module cci_sqrt #(
  parameter int W  = 8,
  parameter int PW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] x,
  input  logic [PW-1:0]  pay_in,
  output logic           out_valid,
  output logic [W-1:0]   root,
  output logic [PW-1:0]  pay_out
);

  logic           vld [W];
  logic [W+1:0]   rem [W];
  logic [W-1:0]   rt  [W];
  logic [2*W-1:0] xs  [W];
  logic [PW-1:0]  pay [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic           pv;
    logic [W+1:0]   prem;
    logic [W-1:0]   proot;
    logic [2*W-1:0] px;
    logic [PW-1:0]  pp;
    logic [W+3:0]   sh;
    logic [W+3:0]   trial;
    logic           ge;
    logic [W+3:0]   nr;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign px    = x;
      assign pp    = pay_in;
    end else begin : g_next
      assign pv    = vld[k-1];
      assign prem  = rem[k-1];
      assign proot = rt[k-1];
      assign px    = xs[k-1];
      assign pp    = pay[k-1];
    end

    // Bring down the next two radicand bits and try a one in this root bit.
    assign sh    = {prem, px[2*W-1:2*W-2]};
    assign trial = (W + 4)'({proot, 2'b01});
    assign ge    = sh >= trial;
    assign nr    = ge ? sh - trial : sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= nr[W+1:0];
        rt[k]  <= {proot[W-2:0], ge};
        xs[k]  <= {px[2*W-3:0], 2'b00};
        pay[k] <= pp;
      end
    end
  end

  assign out_valid = vld[W-1];
  assign root      = rt[W-1];
  assign pay_out   = pay[W-1];

endmodule

// ===== hdl/cci_back.sv =====
// Back end: exact circumcenter, radius and incircle arithmetic in a stalling
// pipeline fed from the queue. Depends on cci_pkg, cci_div and cci_sqrt.
module cci_back #(
  parameter int COORD_WIDTH = 32,
  localparam int D      = COORD_WIDTH + 1,
  localparam int FW     = 2 * COORD_WIDTH + 6 * D,
  localparam int INC_W  = (2 * COORD_WIDTH < 64) ? 2 * COORD_WIDTH : 64,
  localparam int OUT_W  = ((3 * COORD_WIDTH + INC_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cci_pkg::qstat_t   qstat,
  input  logic [FW-1:0]     qdata,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [1:0]        m_tuser
);
  import cci_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int NW  = 3 * D;           // numerator magnitude
  localparam int DW  = 2 * D + 1;       // denominator magnitude
  localparam int QW  = NW + 2;          // signed center offset
  localparam int PW  = W + W + D + D + (2 * D + 1) + 2;
  localparam int IW  = D + QW + 3;      // exact incircle value
  localparam int SPW = 2 * W + INC_W + 3;

  logic en;
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !qstat.empty;

  // Stage 1: products of the offsets.
  logic                  v1;
  logic signed [W-1:0]   s1_a0, s1_a1;
  logic signed [D-1:0]   s1_ba0, s1_ba1, s1_ca0, s1_ca1, s1_e0, s1_e1;
  logic signed [2*D-1:0] s1_mbc, s1_mcb, s1_sbx, s1_sby, s1_scx, s1_scy, s1_sex, s1_sey;
  logic signed [W-1:0]   q_a0, q_a1;
  logic signed [D-1:0]   q_ba0, q_ba1, q_ca0, q_ca1, q_e0, q_e1;

  assign q_a0  = $signed(qdata[0 +: W]);
  assign q_a1  = $signed(qdata[W +: W]);
  assign q_ba0 = $signed(qdata[2*W +: D]);
  assign q_ba1 = $signed(qdata[2*W+D +: D]);
  assign q_ca0 = $signed(qdata[2*W+2*D +: D]);
  assign q_ca1 = $signed(qdata[2*W+3*D +: D]);
  assign q_e0  = $signed(qdata[2*W+4*D +: D]);
  assign q_e1  = $signed(qdata[2*W+5*D +: D]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a0  <= q_a0;
      s1_a1  <= q_a1;
      s1_ba0 <= q_ba0;
      s1_ba1 <= q_ba1;
      s1_ca0 <= q_ca0;
      s1_ca1 <= q_ca1;
      s1_e0  <= q_e0;
      s1_e1  <= q_e1;
      s1_mbc <= q_ba0 * q_ca1;
      s1_mcb <= q_ca0 * q_ba1;
      s1_sbx <= q_ba0 * q_ba0;
      s1_sby <= q_ba1 * q_ba1;
      s1_scx <= q_ca0 * q_ca0;
      s1_scy <= q_ca1 * q_ca1;
      s1_sex <= q_e0 * q_e0;
      s1_sey <= q_e1 * q_e1;
    end
  end

  // Stage 2: determinant and squared lengths.
  logic                  v2;
  logic signed [W-1:0]   s2_a0, s2_a1;
  logic signed [D-1:0]   s2_ba0, s2_ba1, s2_ca0, s2_ca1, s2_e0, s2_e1;
  logic signed [2*D:0]   s2_det, s2_asq, s2_csq, s2_dsq;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a0  <= s1_a0;
      s2_a1  <= s1_a1;
      s2_ba0 <= s1_ba0;
      s2_ba1 <= s1_ba1;
      s2_ca0 <= s1_ca0;
      s2_ca1 <= s1_ca1;
      s2_e0  <= s1_e0;
      s2_e1  <= s1_e1;
      s2_det <= s1_mbc - s1_mcb;
      s2_asq <= s1_sbx + s1_sby;
      s2_csq <= s1_scx + s1_scy;
      s2_dsq <= s1_sex + s1_sey;
    end
  end

  // Stage 3: partial numerator products, denominator magnitude and the degenerate
  // case. The squared lengths are split in a high and a low half so that each
  // multiplier stays near the offset width.
  logic                  v3;
  logic signed [W-1:0]   s3_a0, s3_a1;
  logic signed [D-1:0]   s3_e0, s3_e1;
  logic signed [2*D:0]   s3_dsq;
  logic signed [2*D:0]   s3_p0ah, s3_p0al, s3_p0ch, s3_p0cl;
  logic signed [2*D:0]   s3_p1ch, s3_p1cl, s3_p1ah, s3_p1al;
  logic [DW-1:0]         s3_den;
  logic                  s3_dneg, s3_degen;
  logic signed [2*D:0]   det_abs;
  logic signed [D:0]     asq_hi, asq_lo, csq_hi, csq_lo;

  assign det_abs = s2_det[2*D] ? -s2_det : s2_det;
  assign asq_hi  = $signed(s2_asq[2*D:D]);
  assign asq_lo  = $signed({1'b0, s2_asq[D-1:0]});
  assign csq_hi  = $signed(s2_csq[2*D:D]);
  assign csq_lo  = $signed({1'b0, s2_csq[D-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a0    <= s2_a0;
      s3_a1    <= s2_a1;
      s3_e0    <= s2_e0;
      s3_e1    <= s2_e1;
      s3_dsq   <= s2_dsq;
      s3_p0ah  <= asq_hi * s2_ca1;
      s3_p0al  <= asq_lo * s2_ca1;
      s3_p0ch  <= csq_hi * s2_ba1;
      s3_p0cl  <= csq_lo * s2_ba1;
      s3_p1ch  <= csq_hi * s2_ba0;
      s3_p1cl  <= csq_lo * s2_ba0;
      s3_p1ah  <= asq_hi * s2_ca0;
      s3_p1al  <= asq_lo * s2_ca0;
      s3_den   <= {det_abs[2*D-1:0], 1'b0};
      s3_dneg  <= s2_det[2*D];
      s3_degen <= s2_det == '0;
    end
  end

  // Stage 3b: the halves are put back together into the numerator products.
  logic                  v3b;
  logic signed [W-1:0]   s3b_a0, s3b_a1;
  logic signed [D-1:0]   s3b_e0, s3b_e1;
  logic signed [2*D:0]   s3b_dsq;
  logic signed [NW:0]    s3b_n0a, s3b_n0b, s3b_n1a, s3b_n1b;
  logic [DW-1:0]         s3b_den;
  logic                  s3b_dneg, s3b_degen;

  always_ff @(posedge clk) begin
    if (en) begin
      s3b_a0    <= s3_a0;
      s3b_a1    <= s3_a1;
      s3b_e0    <= s3_e0;
      s3b_e1    <= s3_e1;
      s3b_dsq   <= s3_dsq;
      s3b_n0a   <= ((NW + 1)'(s3_p0ah) <<< D) + (NW + 1)'(s3_p0al);
      s3b_n0b   <= ((NW + 1)'(s3_p0ch) <<< D) + (NW + 1)'(s3_p0cl);
      s3b_n1a   <= ((NW + 1)'(s3_p1ch) <<< D) + (NW + 1)'(s3_p1cl);
      s3b_n1b   <= ((NW + 1)'(s3_p1ah) <<< D) + (NW + 1)'(s3_p1al);
      s3b_den   <= s3_den;
      s3b_dneg  <= s3_dneg;
      s3b_degen <= s3_degen;
    end
  end

  // Stage 4: numerators.
  logic                  v4;
  logic signed [W-1:0]   s4_a0, s4_a1;
  logic signed [D-1:0]   s4_e0, s4_e1;
  logic signed [2*D:0]   s4_dsq;
  logic signed [NW+1:0]  s4_num0, s4_num1;
  logic [DW-1:0]         s4_den;
  logic                  s4_dneg, s4_degen;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_a0    <= s3b_a0;
      s4_a1    <= s3b_a1;
      s4_e0    <= s3b_e0;
      s4_e1    <= s3b_e1;
      s4_dsq   <= s3b_dsq;
      s4_num0  <= s3b_n0a - s3b_n0b;
      s4_num1  <= s3b_n1a - s3b_n1b;
      s4_den   <= s3b_den;
      s4_dneg  <= s3b_dneg;
      s4_degen <= s3b_degen;
    end
  end

  // Stage 5: magnitudes and quotient signs for the dividers.
  logic                  v5;
  logic [PW-1:0]         s5_pay;
  logic [NW-1:0]         s5_mag0, s5_mag1;
  logic [DW-1:0]         s5_den;
  logic                  s5_neg1;
  logic signed [NW+1:0]  abs0, abs1;

  assign abs0 = s4_num0[NW+1] ? -s4_num0 : s4_num0;
  assign abs1 = s4_num1[NW+1] ? -s4_num1 : s4_num1;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pay  <= {s4_degen, s4_num0[NW+1] ^ s4_dneg, s4_dsq, s4_e1, s4_e0, s4_a1, s4_a0};
      s5_mag0 <= abs0[NW-1:0];
      s5_mag1 <= abs1[NW-1:0];
      s5_den  <= s4_den;
      s5_neg1 <= s4_num1[NW+1] ^ s4_dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v3b <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
    end else if (en) begin
      v1  <= pop;
      v2  <= v1;
      v3  <= v2;
      v3b <= v3;
      v4  <= v3b;
      v5  <= v4;
    end
  end

  logic          d_valid;
  logic [NW-1:0] d_q0, d_q1;
  logic          d_rnd0, d_rnd1;
  logic [PW-1:0] d_pay;
  logic          d_neg1;
  logic          d_unused_valid;

  cci_div #(.NW(NW), .DW(DW), .PW(PW)) u_div0 (
    .clk, .rst, .en,
    .in_valid (v5),
    .num      (s5_mag0),
    .den      (s5_den),
    .pay_in   (s5_pay),
    .out_valid(d_valid),
    .quo      (d_q0),
    .round_up (d_rnd0),
    .pay_out  (d_pay)
  );

  cci_div #(.NW(NW), .DW(DW), .PW(1)) u_div1 (
    .clk, .rst, .en,
    .in_valid (v5),
    .num      (s5_mag1),
    .den      (s5_den),
    .pay_in   (s5_neg1),
    .out_valid(d_unused_valid),
    .quo      (d_q1),
    .round_up (d_rnd1),
    .pay_out  (d_neg1)
  );

  // Stage 6: rounding, halves away from zero on the magnitude.
  logic                  v6;
  logic [PW-1:0]         s6_pay;
  logic                  s6_neg1;
  logic [NW:0]           s6_qr0, s6_qr1;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pay  <= d_pay;
      s6_neg1 <= d_neg1 && d_unused_valid;
      s6_qr0  <= (NW + 1)'(d_q0) + (NW + 1)'(d_rnd0);
      s6_qr1  <= (NW + 1)'(d_q1) + (NW + 1)'(d_rnd1);
    end
  end

  logic signed [W-1:0]   p6_a0, p6_a1;
  logic signed [D-1:0]   p6_e0, p6_e1;
  logic signed [2*D:0]   p6_dsq;
  logic                  p6_neg0, p6_degen;

  assign {p6_degen, p6_neg0, p6_dsq, p6_e1, p6_e0, p6_a1, p6_a0} = s6_pay;

  // Stage 7: signed offsets, and magnitudes clamped for the radius path.
  logic                  v7;
  logic signed [W-1:0]   s7_a0, s7_a1;
  logic signed [D-1:0]   s7_e0, s7_e1;
  logic signed [2*D:0]   s7_dsq;
  logic                  s7_degen;
  logic signed [QW-1:0]  s7_u0, s7_u1;
  logic [W:0]            s7_uc0, s7_uc1;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_a0    <= p6_a0;
      s7_a1    <= p6_a1;
      s7_e0    <= p6_e0;
      s7_e1    <= p6_e1;
      s7_dsq   <= p6_dsq;
      s7_degen <= p6_degen;
      s7_u0    <= p6_neg0 ? -$signed({1'b0, s6_qr0}) : $signed({1'b0, s6_qr0});
      s7_u1    <= s6_neg1 ? -$signed({1'b0, s6_qr1}) : $signed({1'b0, s6_qr1});
      s7_uc0   <= (s6_qr0[NW:W] != '0) ? {1'b1, {W{1'b0}}} : {1'b0, s6_qr0[W-1:0]};
      s7_uc1   <= (s6_qr1[NW:W] != '0) ? {1'b1, {W{1'b0}}} : {1'b0, s6_qr1[W-1:0]};
    end
  end

  // Stage 8: centers, partial cross terms d.u, and clamped squares.
  // rsq - dist reduces to 2(e.u) - |e|^2, so the huge squares of u are not needed.
  // Each offset is cut into a low, a middle and a high slice for the cross terms.
  logic                   v8;
  logic signed [2*D:0]    s8_dsq;
  logic                   s8_degen;
  logic signed [QW:0]     s8_cs0, s8_cs1;
  logic signed [2*D:0]    s8_p0l, s8_p0m, s8_p1l, s8_p1m;
  logic signed [2*D+1:0]  s8_p0h, s8_p1h;
  logic [2*W+1:0]         s8_sq0, s8_sq1;
  logic signed [D:0]      u0_lo, u0_mid, u1_lo, u1_mid;
  logic signed [D+1:0]    u0_hi, u1_hi;

  assign u0_lo  = $signed({1'b0, s7_u0[D-1:0]});
  assign u0_mid = $signed({1'b0, s7_u0[2*D-1:D]});
  assign u0_hi  = $signed(s7_u0[QW-1:2*D]);
  assign u1_lo  = $signed({1'b0, s7_u1[D-1:0]});
  assign u1_mid = $signed({1'b0, s7_u1[2*D-1:D]});
  assign u1_hi  = $signed(s7_u1[QW-1:2*D]);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_dsq   <= s7_dsq;
      s8_degen <= s7_degen;
      s8_cs0   <= s7_u0 + s7_a0;
      s8_cs1   <= s7_u1 + s7_a1;
      s8_p0l   <= s7_e0 * u0_lo;
      s8_p0m   <= s7_e0 * u0_mid;
      s8_p0h   <= s7_e0 * u0_hi;
      s8_p1l   <= s7_e1 * u1_lo;
      s8_p1m   <= s7_e1 * u1_mid;
      s8_p1h   <= s7_e1 * u1_hi;
      s8_sq0   <= s7_uc0 * s7_uc0;
      s8_sq1   <= s7_uc1 * s7_uc1;
    end
  end

  // Stage 8b: cross terms assembled from their slices.
  logic                   v8b;
  logic signed [2*D:0]    s8b_dsq;
  logic                   s8b_degen;
  logic signed [QW:0]     s8b_cs0, s8b_cs1;
  logic signed [D+QW-1:0] s8b_p0, s8b_p1;
  logic [2*W+1:0]         s8b_sq0, s8b_sq1;

  always_ff @(posedge clk) begin
    if (en) begin
      s8b_dsq   <= s8_dsq;
      s8b_degen <= s8_degen;
      s8b_cs0   <= s8_cs0;
      s8b_cs1   <= s8_cs1;
      s8b_p0    <= ((D + QW)'(s8_p0h) <<< (2 * D)) + ((D + QW)'(s8_p0m) <<< D)
                   + (D + QW)'(s8_p0l);
      s8b_p1    <= ((D + QW)'(s8_p1h) <<< (2 * D)) + ((D + QW)'(s8_p1m) <<< D)
                   + (D + QW)'(s8_p1l);
      s8b_sq0   <= s8_sq0;
      s8b_sq1   <= s8_sq1;
    end
  end

  // Stage 9: center saturation, sums.
  logic                  v9;
  logic signed [2*D:0]   s9_dsq;
  logic                  s9_degen;
  logic signed [D+QW:0]  s9_t;
  logic [2*W+1:0]        s9_rsq;
  logic [W-1:0]          s9_cx, s9_cy;
  logic                  s9_ovc;
  logic                  fit0, fit1;

  assign fit0 = (&s8b_cs0[QW:W-1]) || !(|s8b_cs0[QW:W-1]);
  assign fit1 = (&s8b_cs1[QW:W-1]) || !(|s8b_cs1[QW:W-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_dsq   <= s8b_dsq;
      s9_degen <= s8b_degen;
      s9_t     <= s8b_p0 + s8b_p1;
      s9_rsq   <= s8b_sq0 + s8b_sq1;
      s9_cx    <= fit0 ? s8b_cs0[W-1:0]
                       : (s8b_cs0[QW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
      s9_cy    <= fit1 ? s8b_cs1[W-1:0]
                       : (s8b_cs1[QW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
      s9_ovc   <= !fit0 || !fit1;
    end
  end

  // Stage 10: exact incircle value; radius squared at or above 2^(2W) saturates.
  logic                  v10;
  logic                  s10_degen;
  logic signed [IW-1:0]  s10_inc;
  logic [2*W+1:0]        s10_rsq;
  logic [W-1:0]          s10_cx, s10_cy;
  logic                  s10_ovc, s10_big;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_degen <= s9_degen;
      s10_inc   <= $signed({s9_t, 1'b0}) - s9_dsq;
      s10_rsq   <= s9_rsq;
      s10_cx    <= s9_cx;
      s10_cy    <= s9_cy;
      s10_ovc   <= s9_ovc;
      s10_big   <= s9_rsq[2*W+1:2*W] != '0;
    end
  end

  // Stage 11: incircle saturation.
  logic                  v11;
  logic [SPW-1:0]        s11_pay;
  logic [2*W-1:0]        s11_x;
  logic                  fiti;
  logic [INC_W-1:0]      inc_sat;

  assign fiti    = (&s10_inc[IW-1:INC_W-1]) || !(|s10_inc[IW-1:INC_W-1]);
  assign inc_sat = fiti ? s10_inc[INC_W-1:0]
                        : (s10_inc[IW-1] ? {1'b1, {(INC_W-1){1'b0}}}
                                         : {1'b0, {(INC_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (en) begin
      s11_pay <= {s10_degen, s10_ovc || !fiti, s10_big, inc_sat, s10_cy, s10_cx};
      s11_x   <= s10_rsq[2*W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v8b <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
    end else if (en) begin
      v6  <= d_valid;
      v7  <= v6;
      v8  <= v7;
      v8b <= v8;
      v9  <= v8b;
      v10 <= v9;
      v11 <= v10;
    end
  end

  logic [W-1:0]     r_root;
  logic [SPW-1:0]   r_pay;
  logic [W-1:0]     o_cx, o_cy, o_rad;
  logic [INC_W-1:0] o_inc;
  logic             o_big, o_ov, o_degen;

  cci_sqrt #(.W(W), .PW(SPW)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (v11),
    .x        (s11_x),
    .pay_in   (s11_pay),
    .out_valid(m_tvalid),
    .root     (r_root),
    .pay_out  (r_pay)
  );

  assign {o_degen, o_ov, o_big, o_inc, o_cy, o_cx} = r_pay;
  assign o_rad = o_big ? {W{1'b1}} : r_root;

  // A collinear triangle gives all zeros apart from the degenerate flag.
  assign m_tdata = o_degen ? '0 : OUT_W'({o_inc, o_rad, o_cy, o_cx});
  assign m_tuser = {(o_ov || o_big) && !o_degen, o_degen};

endmodule

// ===== hdl/circumcircle_incircle_test_top.sv =====
// Top level of the circumcircle and incircle test block.
// Depends on cci_pkg, cci_front, cci_fifo and cci_back.

// Takes one triangle and query point per cycle and returns one result per
// request, in order. Throughput is one request per clock while m_tready stays high;
// the pipeline length is set mostly by the bit-per-stage dividers for the
// circumcenter (3*(COORD_WIDTH+1) stages) and the bit-per-stage square root for
// the radius (COORD_WIDTH stages). A four-entry queue between the input stage and
// the arithmetic pipeline absorbs short output stalls; while m_tready is low the
// pipeline holds and s_tready drops once the queue fills.
module circumcircle_incircle_test_top #(
  parameter int COORD_WIDTH = 32,
  localparam int INC_W = (2 * COORD_WIDTH < 64) ? 2 * COORD_WIDTH : 64,
  localparam int OUT_W = ((3 * COORD_WIDTH + INC_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy
  input  logic [8*COORD_WIDTH-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // center_x, center_y, radius, incircle_value, zero fill
  output logic [OUT_W-1:0]         m_tdata,
  // degenerate, overflow
  output logic [1:0]               m_tuser
);
  import cci_pkg::*;

  localparam int D  = COORD_WIDTH + 1;
  localparam int FW = 2 * COORD_WIDTH + 6 * D;

  qstat_t        qstat;
  logic          push, pop;
  logic [FW-1:0] pdata, qdata;

  cci_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .qstat,
    .push,
    .pdata
  );

  cci_fifo #(.WIDTH(FW)) u_fifo (
    .clk, .rst,
    .push,
    .wdata(pdata),
    .pop,
    .rdata(qdata),
    .stat (qstat)
  );

  cci_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst,
    .qstat,
    .qdata,
    .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule

// ===== hdl/cci_checker.sv =====
// Port checker for the circumcircle and incircle test block, bound to the top.
// Depends on circumcircle_incircle_test_top_assert.svh.
`include "circumcircle_incircle_test_top_assert.svh"

module cci_checker #(
  parameter int COORD_WIDTH = 32,
  localparam int INC_W = (2 * COORD_WIDTH < 64) ? 2 * COORD_WIDTH : 64,
  localparam int OUT_W = ((3 * COORD_WIDTH + INC_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [1:0]       m_tuser
);

  // A degenerate result carries only the flag.
  `CCI_CHECK(a_degen_zero, m_tvalid && m_tuser[0] |-> !m_tuser[1] && (m_tdata == '0), "degenerate result not cleared")

  // A stalled result holds.
  `CCI_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // Reset empties the pipeline.
  `CCI_CHECK_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind circumcircle_incircle_test_top cci_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cci_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

// ===== bench/tb.sv =====
// Self-checking testbench for circumcircle_incircle_test_top.
// Needs only the RTL. It predicts each result with wide integer arithmetic and
// checks the results in order, with random input gaps and output stalls.
`timescale 1ns / 100ps

module tb;

  localparam int CW = 32;
  localparam int IW = 64;
  localparam int DRAIN_CYCLES = 400;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLDOFF_CYCLES = 700;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [CW-1:0] center_x;
    logic [CW-1:0] center_y;
    logic [CW-1:0] radius;
    logic [IW-1:0] incircle_value;
    logic          degenerate;
    logic          overflow;
  } circle_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [8*CW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic [1:0] m_tuser;

  logic [8*CW-1:0] pending_points[$];
  circle_result_t expected_circles[$];
  int mismatches = 0;
  int requests_taken = 0;
  bit req_fired = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int stall_pct = 0;
  int stall_phase = 0;
  int idle_cycles = 0;

  circumcircle_incircle_test_top #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Saturates a wide value into a signed field of the given width.
  function automatic logic [63:0] clamp_signed(input wide_t v, input int width,
                                               inout logic ov);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (width - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ov = 1'b1;
      return hi[63:0];
    end
    if (v < lo) begin
      ov = 1'b1;
      return lo[63:0];
    end
    return v[63:0];
  endfunction

  // Quotient rounded to nearest, halves away from zero.
  function automatic wide_t div_nearest(input wide_t num, input wide_t den);
    wide_t n;
    wide_t d;
    wide_t q;
    wide_t r;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (2 * r >= d) q = q + 1;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic circle_result_t predict_circle(input logic [8*CW-1:0] w);
    circle_result_t res;
    wide_t a0, a1, ba0, ba1, ca0, ca1, e0, e1;
    wide_t det, asq, csq, u0, u1, rsq, dist_sq, cand;
    logic [CW-1:0] root;
    logic [CW-1:0] trial;
    logic ov;
    logic [63:0] sat;
    a0 = $signed(w[0*CW +: CW]);
    a1 = $signed(w[1*CW +: CW]);
    ba0 = wide_t'($signed(w[2*CW +: CW])) - a0;
    ba1 = wide_t'($signed(w[3*CW +: CW])) - a1;
    ca0 = wide_t'($signed(w[4*CW +: CW])) - a0;
    ca1 = wide_t'($signed(w[5*CW +: CW])) - a1;
    e0 = wide_t'($signed(w[6*CW +: CW])) - a0;
    e1 = wide_t'($signed(w[7*CW +: CW])) - a1;
    res = '{default: '0};
    ov = 1'b0;
    det = ba0 * ca1 - ca0 * ba1;
    if (det == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    asq = ba0 * ba0 + ba1 * ba1;
    csq = ca0 * ca0 + ca1 * ca1;
    u0 = div_nearest(asq * ca1 - csq * ba1, 2 * det);
    u1 = div_nearest(csq * ba0 - asq * ca0, 2 * det);
    sat = clamp_signed(u0 + a0, CW, ov);
    res.center_x = sat[CW-1:0];
    sat = clamp_signed(u1 + a1, CW, ov);
    res.center_y = sat[CW-1:0];
    rsq = u0 * u0 + u1 * u1;
    root = '0;
    for (int b = CW - 1; b >= 0; b--) begin
      trial = root | (CW'(1) << b);
      cand = wide_t'({1'b0, trial});
      if (cand * cand <= rsq) root = trial;
    end
    res.radius = root;
    if (rsq >= (wide_t'(1) <<< (2 * CW))) ov = 1'b1;
    e0 = e0 - u0;
    e1 = e1 - u1;
    dist_sq = e0 * e0 + e1 * e1;
    res.incircle_value = clamp_signed(rsq - dist_sq, IW, ov);
    res.overflow = ov;
    return res;
  endfunction

  task automatic add_points(input int ax, ay, bx, by_coord, cx, cy, dx, dy);
    pending_points.push_back({dy, dx, cy, cx, by_coord, bx, ay, ax});
  endtask

  function automatic int small_coord(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_random_points();
    int kind;
    int ax, ay, vx, vy, k, m;
    kind = $urandom_range(0, 9);
    ax = small_coord(1 << 20);
    ay = small_coord(1 << 20);
    case (kind) inside
      5, 6: begin
        add_points($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end
      7, 8: begin
        // Points on a line; one unit of nudge leaves a nearly flat triangle.
        vx = small_coord(1 << 10);
        vy = small_coord(1 << 10);
        k = small_coord(64);
        m = small_coord(64);
        add_points(ax, ay, ax + k * vx, ay + k * vy,
                   ax + m * vx + ((kind == 8) ? 1 : 0), ay + m * vy,
                   small_coord(1 << 20), small_coord(1 << 20));
      end
      9: begin
        vx = small_coord(1 << 18);
        vy = small_coord(1 << 18);
        add_points(ax, ay, ax + vx, ay + small_coord(1 << 18),
                   ax + small_coord(1 << 18), ay + vy, ax, ay);
      end
      default: begin
        add_points(ax, ay, small_coord(1 << 20), small_coord(1 << 20),
                   small_coord(1 << 20), small_coord(1 << 20),
                   small_coord(1 << 21), small_coord(1 << 21));
      end
    endcase
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !req_fired) begin
        s_tvalid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        s_tdata <= pending_points.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall levels, plus one long hold-off to fill the block.
  always @(negedge clk) begin
    if (!rst) begin
      if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        m_tready <= 1'b0;
      end else if (!holdoff_done && requests_taken >= 300) begin
        holdoff_done <= 1'b1;
        holdoff_left <= HOLDOFF_CYCLES;
        m_tready <= 1'b0;
      end else begin
        if (stall_phase == 0) begin
          stall_phase <= $urandom_range(16, 128);
          case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 20;
            2: stall_pct <= 50;
            default: stall_pct <= 85;
          endcase
        end else begin
          stall_phase <= stall_phase - 1;
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    circle_result_t want;
    req_fired = s_tvalid && s_tready && !rst;
    if (req_fired) begin
      expected_circles.push_back(predict_circle(s_tdata));
      requests_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_circles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending: %h", m_tdata);
      end else begin
        want = expected_circles.pop_front();
        if (m_tdata[31:0] !== want.center_x || m_tdata[63:32] !== want.center_y ||
            m_tdata[95:64] !== want.radius || m_tdata[159:96] !== want.incircle_value ||
            m_tuser[0] !== want.degenerate || m_tuser[1] !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected cx=%h cy=%h r=%h inc=%h deg=%b ov=%b, got %h user=%b",
                     want.center_x, want.center_y, want.radius, want.incircle_value,
                     want.degenerate, want.overflow, m_tdata, m_tuser);
        end
      end
    end
    if (!rst && !req_fired && !(m_tvalid && m_tready)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("circumcircle_incircle_test_top: mismatch");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    // Collinear and coincident points.
    add_points(0, 0, 0, 0, 0, 0, 0, 0);
    add_points(0, 0, 65536, 65536, 131072, 131072, 5, 5);
    add_points(-5, 7, -5, 7, 100, 3, 0, 0);
    // Unit right triangle with the query inside, on and outside the circle.
    add_points(0, 0, 65536, 0, 0, 65536, 32768, 32768);
    add_points(0, 0, 65536, 0, 0, 65536, 65536, 65536);
    add_points(0, 0, 65536, 0, 0, 65536, 200000, -200000);
    add_points(0, 0, 3, 0, 0, 3, 1, 1);
    add_points(0, 0, 1, 0, 0, 1, 0, 1);
    // Extremes of the coordinate range.
    add_points(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_points(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_points(32'h8000_0000, 0, 32'h7fff_ffff, 1, 0, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000);
    add_points(-1, -1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, -1, 0);
    // Nearly flat triangles push the center far out and saturate.
    add_points(0, 0, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_fffd, 0, 0);
    add_points(0, 0, 1000000, 1, 2000000, 3, 0, 0);
    add_points(0, 0, 1000000, 1, -2000000, -1, 0, 0);
    add_points(0, 0, 32'h4000_0000, 1, 32'h8000_0000, 32'h8000_0000, 1, -1);
    // Rounding of halves in both signs.
    add_points(0, 0, 1, 0, 0, 1, 0, 0);
    add_points(0, 0, -1, 0, 0, -1, 0, 0);
    add_points(10, 10, 11, 10, 10, 11, 10, 10);
    for (int i = 0; i < 900; i++) add_random_points();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_points.size() == 0 && !s_tvalid);
    wait (expected_circles.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_circles.size() == 0) begin
      $display("circumcircle_incircle_test_top: match");
    end else begin
      $display("circumcircle_incircle_test_top: mismatch");
    end
    $finish;
  end

endmodule
